// File: rtl/hra_pkg.sv
// ----------------------------------------------------------------------------
// hra_pkg: shared definitions for the host register allocator
// Command, status and mapping codes, the allocation priority table and the
// control/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package hra_pkg;

    // Table size and field widths
    localparam int NUM_HOST_REGS = 16;
    localparam int REG_W         = 4;
    localparam int REQ_W         = 5;
    localparam int GUEST_W       = 6;
    localparam int CMD_W         = 3;
    localparam int VAR_W         = 3;
    localparam int STAT_W        = 3;
    localparam int KIND_W        = 2;
    localparam int AGE_W         = 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_MAP_TEMP   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MAP_VAR    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BEGIN_CALL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_END_CALL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNPROTECT  = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_LOCKED   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_FREE  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_CONFLICT = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BAD_VAR  = 3'd4;

    // Mapping kinds
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GPR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEMP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_VAR  = 2'd3;

    // Variables
    localparam logic [VAR_W-1:0] VAR_GPR        = 3'd0;
    localparam logic [VAR_W-1:0] VAR_FPR        = 3'd1;
    localparam logic [VAR_W-1:0] VAR_TLB_MAP    = 3'd2;
    localparam logic [VAR_W-1:0] VAR_NEXT_TIMER = 3'd3;
    localparam logic [VAR_W-1:0] VAR_INVALID    = 3'd4;
    localparam logic [VAR_W-1:0] VAR_UNKNOWN    = 3'd7;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // Allocation priority: R7..R0, then R12..R8
    localparam int PRIO_COUNT = 13;
    localparam logic [REG_W-1:0] PRIO_ORDER [PRIO_COUNT] = '{
        4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0,
        4'd12, 4'd11, 4'd10, 4'd9, 4'd8
    };

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_GPR,
        S_TEMP,
        S_EXEC,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture the input item
        logic step_gpr;   // map the GPR pointer ahead of a temp
        logic step_temp;  // allocate the temp register
        logic step_exec;  // single-step commands
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic call_lock;
    } t_dp_status;

endpackage

// File: rtl/hra_ctrl.sv
// ----------------------------------------------------------------------------
// hra_ctrl: sequencing state machine
// Accepts one item, steps the datapath through its phases and holds the
// result until it is taken.
// ----------------------------------------------------------------------------
module hra_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [hra_pkg::CMD_W-1:0]     i_command,
    input  logic                          i_guest_neg,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  hra_pkg::t_dp_status           i_dp_status,
    output hra_pkg::t_ctrl_cmd            o_cmd
);
    import hra_pkg::*;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_MAP_TEMP && !i_dp_status.call_lock) begin
                        n_state = i_guest_neg ? S_TEMP : S_GPR;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_GPR:  n_state = S_TEMP;
            S_TEMP: n_state = S_DONE;
            S_EXEC: n_state = S_DONE;
            S_DONE: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.latch  = i_in_valid;
            end
            S_GPR:  o_cmd.step_gpr  = 1'b1;
            S_TEMP: o_cmd.step_temp = 1'b1;
            S_EXEC: o_cmd.step_exec = 1'b1;
            S_DONE: o_out_valid     = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/hra_datapath.sv
// ----------------------------------------------------------------------------
// hra_datapath: register table and allocation logic
// Holds the mapping table and call lock, searches it by match and fixed
// priority, and applies one phase of a command per step.
// ----------------------------------------------------------------------------
module hra_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hra_pkg::t_ctrl_cmd                i_cmd,
    output hra_pkg::t_dp_status               o_dp_status,
    input  logic [hra_pkg::CMD_W-1:0]         i_command,
    input  logic [hra_pkg::REQ_W-1:0]         i_requested_reg,
    input  logic [hra_pkg::VAR_W-1:0]         i_variable_id,
    output logic [hra_pkg::REG_W-1:0]         o_granted_reg,
    output logic [hra_pkg::STAT_W-1:0]        o_status
);
    import hra_pkg::*;

    // Table and lock
    logic [KIND_W-1:0]     r_kind [NUM_HOST_REGS];
    logic [KIND_W-1:0]     n_kind [NUM_HOST_REGS];
    logic [NUM_HOST_REGS-1:0] r_prot, n_prot;
    logic [AGE_W-1:0]      r_age  [NUM_HOST_REGS];
    logic [AGE_W-1:0]      n_age  [NUM_HOST_REGS];
    logic [VAR_W-1:0]      r_mvar [NUM_HOST_REGS];
    logic [VAR_W-1:0]      n_mvar [NUM_HOST_REGS];
    logic                  r_lock, n_lock;

    // Latched item and per-item scratch
    logic [CMD_W-1:0]      r_command;
    logic [REQ_W-1:0]      r_req;
    logic [VAR_W-1:0]      r_var;
    logic                  r_gpr_ok, n_gpr_ok;
    logic [REG_W-1:0]      r_gpr_reg, n_gpr_reg;
    logic                  r_conflict, n_conflict;
    logic [REG_W-1:0]      r_granted, n_granted;
    logic [STAT_W-1:0]     r_status, n_status;

    // Search results
    logic [VAR_W-1:0]      mv_var;
    logic                  match_hit;
    logic [REG_W-1:0]      match_idx;
    logic                  temp_hit;
    logic [REG_W-1:0]      temp_idx;
    logic                  free_hit;
    logic [REG_W-1:0]      free_idx;
    logic                  req_any;
    logic [REG_W-1:0]      tgt_reg;
    logic                  tgt_ok;
    logic                  tgt_conflict;

    assign o_dp_status.call_lock = r_lock;
    assign o_granted_reg         = r_granted;
    assign o_status              = r_status;

    // Search the table: variable match, temp by priority, temp-or-free by priority
    always_comb begin
        mv_var    = i_cmd.step_gpr ? VAR_GPR : r_var;
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = NUM_HOST_REGS - 1; i >= 0; i--) begin
            if (mv_var < VAR_INVALID && r_kind[i] == KIND_VAR && r_mvar[i] == mv_var) begin
                match_hit = 1'b1;
                match_idx = REG_W'(i);
            end
        end
        temp_hit = 1'b0;
        temp_idx = '0;
        free_hit = 1'b0;
        free_idx = '0;
        for (int k = PRIO_COUNT - 1; k >= 0; k--) begin
            if (int'(PRIO_ORDER[k]) < NUM_HOST_REGS && !r_prot[PRIO_ORDER[k]]) begin
                if (r_kind[PRIO_ORDER[k]] == KIND_TEMP) begin
                    temp_hit = 1'b1;
                    temp_idx = PRIO_ORDER[k];
                end
                if (r_kind[PRIO_ORDER[k]] == KIND_TEMP ||
                    r_kind[PRIO_ORDER[k]] == KIND_NONE) begin
                    free_hit = 1'b1;
                    free_idx = PRIO_ORDER[k];
                end
            end
        end
    end

    // Pick the temp target register
    always_comb begin
        req_any      = r_req >= REQ_W'(NUM_HOST_REGS);
        tgt_ok       = 1'b1;
        tgt_conflict = 1'b0;
        if (req_any) begin
            tgt_reg = temp_hit ? temp_idx : free_idx;
            tgt_ok  = temp_hit || free_hit;
        end else begin
            tgt_reg = r_req[REG_W-1:0];
            if (r_kind[tgt_reg] == KIND_NONE || r_kind[tgt_reg] == KIND_TEMP) begin
                tgt_conflict = r_prot[tgt_reg];
            end else begin
                tgt_conflict = 1'b1;
            end
        end
    end

    // Apply one phase of the current command
    always_comb begin
        n_kind     = r_kind;
        n_prot     = r_prot;
        n_age      = r_age;
        n_mvar     = r_mvar;
        n_lock     = r_lock;
        n_gpr_ok   = r_gpr_ok;
        n_gpr_reg  = r_gpr_reg;
        n_conflict = r_conflict;
        n_granted  = r_granted;
        n_status   = r_status;

        if (i_cmd.latch) begin
            n_gpr_ok   = 1'b0;
            n_conflict = 1'b0;
        end

        // Variable mapping, shared by the GPR pointer phase and the variable command
        if (i_cmd.step_gpr || (i_cmd.step_exec && r_command == CMD_MAP_VAR && !r_lock)) begin
            n_granted = '0;
            if (match_hit) begin
                n_prot[match_idx] = 1'b1;
                n_granted         = match_idx;
                n_status          = STAT_OK;
            end else if (free_hit) begin
                n_kind[free_idx] = KIND_VAR;
                n_prot[free_idx] = 1'b1;
                if (mv_var >= VAR_INVALID) begin
                    n_status = STAT_BAD_VAR;
                end else begin
                    n_mvar[free_idx] = mv_var;
                    n_granted        = free_idx;
                    n_status         = STAT_OK;
                end
            end else begin
                n_status = STAT_NO_FREE;
            end
            if (i_cmd.step_gpr) begin
                n_gpr_ok   = (match_hit || free_hit);
                n_gpr_reg  = match_hit ? match_idx : free_idx;
                n_conflict = !(match_hit || free_hit);
            end
        end

        // Temp allocation with aging
        if (i_cmd.step_temp) begin
            if (!tgt_ok) begin
                n_granted = '0;
                n_status  = STAT_NO_FREE;
            end else begin
                for (int i = 0; i < NUM_HOST_REGS; i++) begin
                    if (r_age[i] != '0 && r_age[i] != AGE_MAX) begin
                        n_age[i] = r_age[i] + AGE_W'(1);
                    end
                end
                n_age[tgt_reg]  = AGE_W'(1);
                n_kind[tgt_reg] = KIND_TEMP;
                n_prot[tgt_reg] = 1'b1;
                if (r_gpr_ok) n_prot[r_gpr_reg] = 1'b0;
                n_granted = tgt_reg;
                n_status  = (r_conflict || tgt_conflict) ? STAT_CONFLICT : STAT_OK;
            end
        end

        // Lock, unprotect and blocked commands
        if (i_cmd.step_exec) begin
            case (r_command)
                CMD_MAP_TEMP: begin
                    n_granted = '0;
                    n_status  = STAT_LOCKED;
                end
                CMD_MAP_VAR: begin
                    if (r_lock) begin
                        n_granted = '0;
                        n_status  = STAT_LOCKED;
                    end
                end
                CMD_BEGIN_CALL: begin
                    n_granted = '0;
                    n_status  = r_lock ? STAT_LOCKED : STAT_OK;
                    n_lock    = 1'b1;
                end
                CMD_END_CALL: begin
                    n_granted = '0;
                    n_status  = r_lock ? STAT_OK : STAT_LOCKED;
                    n_lock    = 1'b0;
                end
                CMD_UNPROTECT: begin
                    n_status = STAT_OK;
                    if (req_any) begin
                        n_prot    = '0;
                        n_granted = '0;
                    end else begin
                        n_prot[r_req[REG_W-1:0]] = 1'b0;
                        n_granted                = r_req[REG_W-1:0];
                    end
                end
                default: begin
                    n_granted = '0;
                    n_status  = STAT_OK;
                end
            endcase
        end
    end

    // Table, lock and per-item control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_HOST_REGS; i++) begin
                r_kind[i] <= KIND_NONE;
                r_age[i]  <= '0;
                r_mvar[i] <= VAR_UNKNOWN;
            end
            r_prot     <= '0;
            r_lock     <= 1'b0;
            r_gpr_ok   <= 1'b0;
            r_conflict <= 1'b0;
        end else begin
            r_kind     <= n_kind;
            r_age      <= n_age;
            r_mvar     <= n_mvar;
            r_prot     <= n_prot;
            r_lock     <= n_lock;
            r_gpr_ok   <= n_gpr_ok;
            r_conflict <= n_conflict;
        end
    end

    // Item payload and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_command <= i_command;
            r_req     <= i_requested_reg;
            r_var     <= i_variable_id;
        end
        r_gpr_reg <= n_gpr_reg;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

endmodule

// File: rtl/host_register_allocator.sv
// ----------------------------------------------------------------------------
// host_register_allocator: host register table with temp and variable mapping
// Takes one command item at a time and returns one result item for each.
// ----------------------------------------------------------------------------
// Sequencing: an accepted item runs the execute phase, or for map_temp with the call
//   lock clear a GPR pointer phase (non-negative guest register only), then a temp phase;
//   no new item is accepted until the result is taken.
// Reset: synchronous, active low; clears the table (not mapped, unprotected,
//   age 0, variable unknown), the call lock and the sequencer.
module host_register_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [hra_pkg::CMD_W-1:0]         i_command,
    input  logic [hra_pkg::REQ_W-1:0]         i_requested_reg,
    input  logic signed [hra_pkg::GUEST_W-1:0] i_guest_reg,
    input  logic [hra_pkg::VAR_W-1:0]         i_variable_id,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [hra_pkg::REG_W-1:0]         o_granted_reg,
    output logic [hra_pkg::STAT_W-1:0]        o_status
);
    import hra_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    hra_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_guest_neg  (i_guest_reg[GUEST_W-1]),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_dp_status  (dp_status),
        .o_cmd        (ctrl_cmd)
    );

    hra_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .o_dp_status     (dp_status),
        .i_command       (i_command),
        .i_requested_reg (i_requested_reg),
        .i_variable_id   (i_variable_id),
        .o_granted_reg   (o_granted_reg),
        .o_status        (o_status)
    );

    // One item in flight: no input accept while a result waits
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // Results carry only defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= STAT_BAD_VAR))
        else $error("undefined status code");

    // Taking a result frees the block for the next item
    a_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (o_in_ready && !o_out_valid))
        else $error("block not ready after result taken");

    // An accepted item produces no result in the very next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid)
        else $error("result appeared too early");

endmodule
